FILE: rtl/cpf_pkg.sv
package cpf_pkg;

    // outer header magic, in the order sent
    localparam logic [7:0] MAGIC_0 = 8'h55;
    localparam logic [7:0] MAGIC_1 = 8'hCC;
    localparam logic [7:0] MAGIC_2 = 8'h49;
    localparam logic [7:0] MAGIC_3 = 8'h57;

    // reflected polynomials
    localparam logic [7:0]  POLY8  = 8'h8C;
    localparam logic [15:0] POLY16 = 16'h8408;

    // configuration register reset values
    localparam logic [7:0]  SHORT_SEED_RST = 8'h77;
    localparam logic [15:0] LONG_SEED_RST  = 16'h3692;

    // configuration register indexes
    localparam logic CFG_SHORT_SEED = 1'b0;
    localparam logic CFG_LONG_SEED  = 1'b1;

    // inner packet length bounds and patched byte positions
    localparam int          LEN_W        = 10;
    localparam logic [9:0]  MIN_LEN      = 10'd10;
    localparam logic [9:0]  POS_SHORT    = 10'd3;
    localparam logic [9:0]  POS_SEQ_LO   = 10'd6;
    localparam logic [9:0]  POS_SEQ_HI   = 10'd7;

    // outer header sequencer: idle, one state per header byte still to send, then the held first byte
    typedef enum logic [8:0] {
        HDR_IDLE   = 9'b000000001,
        HDR_MAGIC1 = 9'b000000010,
        HDR_MAGIC2 = 9'b000000100,
        HDR_MAGIC3 = 9'b000001000,
        HDR_LEN_LO = 9'b000010000,
        HDR_LEN_HI = 9'b000100000,
        HDR_SEQ_LO = 9'b001000000,
        HDR_SEQ_HI = 9'b010000000,
        HDR_BODY   = 9'b100000000
    } t_hdr_state;

    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] v;
        v = c ^ d;
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ POLY8) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] v;
        v = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ POLY16) : (v >> 1);
        end
        return v;
    endfunction

endpackage

FILE: rtl/command_packet_framer_crc_unit.sv
// Command packet framer. Takes the bytes of one inner command packet and sends the framed
// packet: the first byte of a packet latches its length (clamped to 10..MAX_PACKET) and
// sequence number, and causes an 8-byte outer header (55 CC 49 57, length low/high, sequence
// low/high) ahead of the first inner byte. Inner byte 3 is replaced by a reflected CRC-8
// (poly 0x8C) over bytes 0..2, bytes 6 and 7 by the sequence, and the last two bytes by a
// reflected CRC-16 (poly 0x8408) over all earlier bytes, low byte first, the final one with
// tlast. Rate: one output transfer per cycle while the receiver is ready and bytes are offered.
// The first byte of a packet holds the input side off after its transfer while the rest of
// the header and that byte leave through the single output register. Both checksum
// updates are byte-wide combinational steps, registered when the byte is accepted. Seeds
// written on the configuration port take effect at the start of the next packet.
module command_packet_framer_crc_unit
    import cpf_pkg::*;
#(
    parameter int MAX_PACKET = 1023
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // inner byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // inner_byte[7:0], packet_length[17:8],
                                         // sequence_number[33:18], zero fill
    // framed byte stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_byte[7:0]
    output logic        o_m_axis_tlast   // end_of_packet
);

    // clamp ceiling fits the 10-bit length field
    localparam logic [LEN_W-1:0] MAX_LEN =
        (MAX_PACKET > 1023) ? 10'd1023 : LEN_W'(MAX_PACKET);

    // configuration registers
    logic [7:0]  r_seed8;
    logic [15:0] r_seed16;

    // packet state
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0]      r_seq, n_seq;
    logic [7:0]       r_short, n_short;
    logic [15:0]      r_long, n_long;
    logic [7:0]       r_held, n_held;
    t_hdr_state       r_hdr, n_hdr;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    logic             out_free;
    logic             hdr_busy;
    logic             s_fire;
    logic [7:0]       in_byte;
    logic [LEN_W-1:0] in_len;
    logic [15:0]      in_seq;
    logic [LEN_W-1:0] len_cl;
    logic             at_crc_lo;
    logic             at_crc_hi;
    logic [7:0]       body_byte;
    logic [7:0]       hdr_byte;

    assign in_byte = i_s_axis_tdata[7:0];
    assign in_len  = i_s_axis_tdata[17:8];
    assign in_seq  = i_s_axis_tdata[33:18];

    // output register can take a new byte when empty or being drained
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign hdr_busy        = (r_hdr != HDR_IDLE);
    assign o_s_axis_tready = !hdr_busy && out_free;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign len_cl = (in_len < MIN_LEN) ? MIN_LEN :
                    (in_len > MAX_LEN) ? MAX_LEN : in_len;

    // trailing checksum positions of the current packet
    assign at_crc_lo = ({1'b0, r_pos} + 11'd2) == {1'b0, r_len};
    assign at_crc_hi = ({1'b0, r_pos} + 11'd1) == {1'b0, r_len};

    // patched inner byte for positions other than the checksum tail
    always_comb begin
        if (r_pos == POS_SHORT) begin
            body_byte = r_short;
        end else if (r_pos == POS_SEQ_LO) begin
            body_byte = r_seq[7:0];
        end else if (r_pos == POS_SEQ_HI) begin
            body_byte = r_seq[15:8];
        end else begin
            body_byte = in_byte;
        end
    end

    // header byte for the current sequencer state
    always_comb begin
        case (r_hdr)
            HDR_MAGIC1: hdr_byte = MAGIC_1;
            HDR_MAGIC2: hdr_byte = MAGIC_2;
            HDR_MAGIC3: hdr_byte = MAGIC_3;
            HDR_LEN_LO: hdr_byte = r_len[7:0];
            HDR_LEN_HI: hdr_byte = {{(16 - LEN_W){1'b0}}, r_len[LEN_W-1:8]};
            HDR_SEQ_LO: hdr_byte = r_seq[7:0];
            HDR_SEQ_HI: hdr_byte = r_seq[15:8];
            HDR_BODY:   hdr_byte = r_held;
            default:    hdr_byte = MAGIC_0;
        endcase
    end

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_seq       = r_seq;
        n_short     = r_short;
        n_long      = r_long;
        n_held      = r_held;
        n_hdr       = r_hdr;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (hdr_busy && out_free) begin
            // rest of the outer header, then the held first inner byte
            n_out_valid = 1'b1;
            n_out_byte  = hdr_byte;
            n_out_last  = 1'b0;
            case (r_hdr)
                HDR_MAGIC1: n_hdr = HDR_MAGIC2;
                HDR_MAGIC2: n_hdr = HDR_MAGIC3;
                HDR_MAGIC3: n_hdr = HDR_LEN_LO;
                HDR_LEN_LO: n_hdr = HDR_LEN_HI;
                HDR_LEN_HI: n_hdr = HDR_SEQ_LO;
                HDR_SEQ_LO: n_hdr = HDR_SEQ_HI;
                HDR_SEQ_HI: n_hdr = HDR_BODY;
                default:    n_hdr = HDR_IDLE;
            endcase
        end else if (s_fire) begin
            n_out_valid = 1'b1;
            if (r_pos == '0) begin
                // first byte: latch packet fields, seed and fold in byte 0
                n_len      = len_cl;
                n_seq      = in_seq;
                n_short    = crc8_step(r_seed8, in_byte);
                n_long     = crc16_step(r_seed16, in_byte);
                n_held     = in_byte;
                n_pos      = 10'd1;
                n_hdr      = HDR_MAGIC1;
                n_out_byte = MAGIC_0;
                n_out_last = 1'b0;
            end else if (at_crc_lo) begin
                n_out_byte = r_long[7:0];
                n_out_last = 1'b0;
                n_pos      = r_pos + 10'd1;
            end else if (at_crc_hi) begin
                n_out_byte = r_long[15:8];
                n_out_last = 1'b1;
                n_pos      = '0;
            end else begin
                n_out_byte = body_byte;
                n_out_last = 1'b0;
                n_pos      = r_pos + 10'd1;
                if (r_pos < POS_SHORT) begin
                    n_short = crc8_step(r_short, body_byte);
                end
                n_long = crc16_step(r_long, body_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed8     <= SHORT_SEED_RST;
            r_seed16    <= LONG_SEED_RST;
            r_pos       <= '0;
            r_len       <= '0;
            r_seq       <= '0;
            r_short     <= '0;
            r_long      <= '0;
            r_hdr       <= HDR_IDLE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SHORT_SEED: r_seed8  <= i_cfg_data[7:0];
                    CFG_LONG_SEED:  r_seed16 <= i_cfg_data;
                    default:        r_seed16 <= r_seed16;
                endcase
            end
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_seq       <= n_seq;
            r_short     <= n_short;
            r_long      <= n_long;
            r_hdr       <= n_hdr;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_out_byte <= n_out_byte;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // input side is held off while the header drains
    a_hdr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_busy |-> !o_s_axis_tready)
        else $error("input accepted during outer header");

    // a first byte opens the header with the first magic byte
    a_first_byte_magic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && r_pos == '0) |=>
            (o_m_axis_tvalid && o_m_axis_tdata == MAGIC_0 && r_hdr == HDR_MAGIC1))
        else $error("header did not start after first byte");

    // a pending final byte means the next input starts a new packet
    a_last_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_pos == '0 && !hdr_busy))
        else $error("tlast sent inside a packet");

    // position stays inside the latched length
    a_pos_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (r_pos < r_len && r_len >= MIN_LEN))
        else $error("byte position beyond packet length");
`endif

endmodule

FILE: sim/command_packet_framer_crc_unit_test.sv
`timescale 1ns / 1ps

module command_packet_framer_crc_unit_test;
    import cpf_pkg::*;

    localparam int MAX_PACKET_LEN = 1023;
    localparam int CLK_HALF       = 6;      // 12 ns period
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 12;     // output register plus margin
    localparam int STALL_LIMIT    = 4000;   // cycles without any transfer

    // one inner byte as it travels on the slave side
    typedef struct packed {
        logic [15:0] seq;
        logic [9:0]  len;
        logic [7:0]  data;
    } t_inner_item;

    // one framed byte as it leaves on the master side
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_framed_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;

    command_packet_framer_crc_unit #(
        .MAX_PACKET(MAX_PACKET_LEN)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // bytes waiting to be sent, and framed bytes still owed by the block
    t_inner_item  inner_pending[$];
    t_inner_item  inner_on_bus;
    t_framed_byte framed_owed[$];

    int send_idle_pct = 21;
    int recv_idle_pct = 83;
    int mismatch_count = 0;
    int stall_cycles = 0;

    // framer model state, seeds included
    logic [7:0]  seed_short = SHORT_SEED_RST;
    logic [15:0] seed_long  = LONG_SEED_RST;
    int          frame_pos  = 0;
    int          frame_len  = 0;
    logic [15:0] frame_seq  = '0;
    logic [7:0]  crc_short  = '0;
    logic [15:0] crc_long   = '0;

    // one byte through a reflected crc; an 8-bit register sits in the low bits
    function automatic logic [15:0] crc_reflected(input logic [15:0] c, input logic [7:0] d,
                                                  input logic [15:0] poly);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
        end
        return r;
    endfunction

    // works out the framed bytes caused by one accepted inner byte
    function automatic void frame_inner_byte(input t_inner_item it);
        logic [7:0]  b;
        logic        last;
        logic [15:0] hdr_len;
        int          len;
        last = 1'b0;
        if (frame_pos == 0) begin
            // first byte: latch length and sequence, load seeds, send outer header
            len = int'(it.len);
            if (len < int'(MIN_LEN)) len = int'(MIN_LEN);
            if (len > MAX_PACKET_LEN) len = MAX_PACKET_LEN;
            frame_len = len;
            hdr_len   = 16'(len);
            frame_seq = it.seq;
            crc_short = seed_short;
            crc_long  = seed_long;
            framed_owed.push_back('{MAGIC_0, 1'b0});
            framed_owed.push_back('{MAGIC_1, 1'b0});
            framed_owed.push_back('{MAGIC_2, 1'b0});
            framed_owed.push_back('{MAGIC_3, 1'b0});
            framed_owed.push_back('{hdr_len[7:0], 1'b0});
            framed_owed.push_back('{hdr_len[15:8], 1'b0});
            framed_owed.push_back('{frame_seq[7:0], 1'b0});
            framed_owed.push_back('{frame_seq[15:8], 1'b0});
        end
        if (frame_pos + 2 == frame_len) begin
            b = crc_long[7:0];
        end else if (frame_pos + 1 == frame_len) begin
            b = crc_long[15:8];
            last = 1'b1;
        end else begin
            // patched positions replace whatever the template holds
            if (frame_pos == int'(POS_SHORT)) begin
                b = crc_short;
            end else if (frame_pos == int'(POS_SEQ_LO)) begin
                b = frame_seq[7:0];
            end else if (frame_pos == int'(POS_SEQ_HI)) begin
                b = frame_seq[15:8];
            end else begin
                b = it.data;
            end
            if (frame_pos < int'(POS_SHORT)) begin
                crc_short = 8'(crc_reflected({8'h00, crc_short}, b, {8'h00, POLY8}));
            end
            crc_long = crc_reflected(crc_long, b, POLY16);
        end
        framed_owed.push_back('{b, last});
        frame_pos = last ? 0 : frame_pos + 1;
    endfunction

    // driver: presents the head of the pending queue, idling at random between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                frame_inner_byte(inner_on_bus);
                void'(inner_pending.pop_front());
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // keep the offered byte steady until it is taken
            end else if (inner_pending.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                inner_on_bus    = inner_pending[0];
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {6'b0, inner_pending[0]};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each framed byte transfer against the oldest owed byte
    always @(posedge i_clk) begin
        t_framed_byte want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (framed_owed.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected framed byte, expected none, actual %02h last %0b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    want = framed_owed.pop_front();
                    if (o_m_axis_tdata !== want.data) begin
                        mismatch_count++;
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.data, o_m_axis_tdata);
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        mismatch_count++;
                        $display("%0t: end_of_packet mismatch, expected %0b, actual %0b",
                                 $time, want.last, o_m_axis_tlast);
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: ends the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL command_packet_framer_crc_unit");
                $finish;
            end
        end
    end

    // one register write, held until the transfer happens
    task automatic write_seed(input logic idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SHORT_SEED) begin
            seed_short = value[7:0];
        end else begin
            seed_long = value;
        end
    endtask

    // waits until every byte has been sent and every framed byte has come back
    task automatic settle();
        while (inner_pending.size() != 0 || i_s_axis_tvalid || framed_owed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // queues count bytes of a packet; fill below zero means random content
    task automatic push_bytes(input logic [9:0] len_field, input logic [15:0] seq,
                              input int fill, input int count, input bit first);
        t_inner_item it;
        for (int k = 0; k < count; k++) begin
            it.data = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            if (first && k == 0) begin
                it.len = len_field;
                it.seq = seq;
            end else begin
                // ignored after the first byte, so send noise there
                it.len = 10'($urandom_range(0, 1023));
                it.seq = 16'($urandom_range(0, 65535));
            end
            inner_pending.push_back(it);
        end
    endtask

    task automatic add_packet(input logic [9:0] len_field, input logic [15:0] seq,
                              input int fill);
        push_bytes(len_field, seq, fill, (len_field < MIN_LEN) ? int'(MIN_LEN) : int'(len_field),
                   1'b1);
    endtask

    // random packets, mostly short with some below the minimum length
    task automatic run_random(input int target, input int send_pct, input int recv_pct);
        logic [9:0] len_field;
        int         queued;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queued = 0;
        while (queued < target) begin
            len_field = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(41, 120))
                                                    : 10'($urandom_range(0, 40));
            add_packet(len_field, 16'($urandom_range(0, 65535)), -1);
            queued += (len_field < MIN_LEN) ? int'(MIN_LEN) : int'(len_field);
        end
        settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lowest seeds first
        write_seed(CFG_SHORT_SEED, 16'h0000);
        write_seed(CFG_LONG_SEED, 16'h0000);

        // zero length clamps up to the minimum, all-ones content and sequence
        add_packet(10'd0, 16'hFFFF, 8'hFF);

        // seeds change in the middle of a packet: only the next packet sees them
        push_bytes(10'd11, 16'h0000, 8'h00, 5, 1'b1);
        settle();
        write_seed(CFG_SHORT_SEED, 16'h00FF);
        write_seed(CFG_LONG_SEED, 16'hFFFF);
        push_bytes(10'd11, 16'h0000, 8'h00, 6, 1'b0);
        settle();

        // slow receiver
        run_random(80, 21, 83);

        write_seed(CFG_SHORT_SEED, 16'($urandom_range(0, 65535)));
        write_seed(CFG_LONG_SEED, 16'($urandom_range(0, 65535)));

        // slow sender
        run_random(80, 83, 21);

        write_seed(CFG_SHORT_SEED, {8'h00, SHORT_SEED_RST});
        write_seed(CFG_LONG_SEED, LONG_SEED_RST);

        // full speed
        run_random(80, 0, 0);

        if (mismatch_count == 0) begin
            $display("PASS command_packet_framer_crc_unit");
        end else begin
            $display("FAIL command_packet_framer_crc_unit");
        end
        $finish;
    end

endmodule
